// ===== design/tile_bitplane_palette_encoder_assert.svh =====
// assertion macros used by the tile encoder design file
`ifndef TILE_BITPLANE_PALETTE_ENCODER_ASSERT_SVH
`define TILE_BITPLANE_PALETTE_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TBPE_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tbpe assertion failed");

// next-cycle implication, disabled during reset
`define TBPE_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tbpe assertion failed");

`endif

// ===== design/tbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpe_pkg
// Widths, codes and types shared by the planar tile encoder and its channels.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam int CHAN_W     = 8;
  localparam int COLOUR_W   = 6;
  localparam int INDEX_W    = 4;
  localparam int PLANES     = 4;
  localparam int ROW_PIXELS = 8;
  localparam int WORD_W     = PLANES * ROW_PIXELS;
  localparam int PRESET_W   = 48;
  localparam int PRESET_PER = 8;
  localparam int COUNT_W    = 5;
  localparam int ROW_W      = 3;
  localparam int CFG_IDX_W  = 2;

  // transaction kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_COUNT = 2'd2;

  localparam logic [ROW_W-1:0] LAST_COLUMN = 3'd7;
  localparam logic [ROW_W-1:0] LAST_ROW    = 3'd7;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [WORD_W-1:0]   word_t;

endpackage

// ===== design/tbpe_channels.sv =====
// ----------------------------------------------------------------------------
// tbpe channels
// Valid/ready channels for pixels in, row words out and register writes.
// ----------------------------------------------------------------------------

// pixel input channel
interface tbpe_pixel_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tbpe_pkg::CHAN_W-1:0]  red;
  logic [tbpe_pkg::CHAN_W-1:0]  green;
  logic [tbpe_pkg::CHAN_W-1:0]  blue;
  logic [tbpe_pkg::CHAN_W-1:0]  alpha;

  modport source (output valid, kind, red, green, blue, alpha, input ready);
  modport sink   (input valid, kind, red, green, blue, alpha, output ready);
endinterface

// row word output channel
interface tbpe_row_if;
  logic                          valid;
  logic                          ready;
  logic [tbpe_pkg::WORD_W-1:0]   row_word;
  logic [tbpe_pkg::ROW_W-1:0]    tile_row;
  logic                          last_row;
  logic [tbpe_pkg::COUNT_W-1:0]  palette_used;
  logic                          palette_overflow;

  modport source (output valid, row_word, tile_row, last_row, palette_used,
                  palette_overflow, input ready);
  modport sink   (input valid, row_word, tile_row, last_row, palette_used,
                  palette_overflow, output ready);
endinterface

// register write channel
interface tbpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tbpe_pkg::CFG_IDX_W-1:0]  index;
  logic [tbpe_pkg::PRESET_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tile_bitplane_palette_encoder.sv =====
// a row word is registered and appears in the cycle after the transaction of its 8th pixel
// throughput: one pixel or restart per cycle; a finished row word waits in the
//   output register and only a transaction at the last column stalls behind it
// the palette match is one bank of parallel comparators plus a priority pick
// reset (rst, synchronous, high) clears position, planes, palette, fill,
//   overflow and the preset registers; no clearing pass is needed
// ----------------------------------------------------------------------------
// tile_bitplane_palette_encoder
// Builds a palette from incoming RGBA pixels and packs 4-bit indexes into
// planar row words, one word for each row of eight pixels.
// ----------------------------------------------------------------------------
`include "tile_bitplane_palette_encoder_assert.svh"

module tile_bitplane_palette_encoder #(
  parameter int PALETTE_ENTRIES = 16
) (
  input logic        clk,
  input logic        rst,
  tbpe_pixel_if.sink pix,
  tbpe_row_if.source row,
  tbpe_cfg_if.sink   cfg
);

  localparam int FW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(PALETTE_ENTRIES);
  localparam logic [tbpe_pkg::COUNT_W-1:0] COUNT_MAX =
    tbpe_pkg::COUNT_W'(PALETTE_ENTRIES);

  // preset registers
  logic [tbpe_pkg::PRESET_W-1:0] preset_low;
  logic [tbpe_pkg::PRESET_W-1:0] preset_high;
  logic [tbpe_pkg::COUNT_W-1:0]  preset_count;

  // encoder state
  tbpe_pkg::colour_t             palette [PALETTE_ENTRIES];
  tbpe_pkg::colour_t             palette_next [PALETTE_ENTRIES];
  tbpe_pkg::colour_t             preset_colours [PALETTE_ENTRIES];
  logic [FW-1:0]                 fill;
  logic [FW-1:0]                 fill_next;
  logic [FW-1:0]                 preset_fill;
  logic [tbpe_pkg::ROW_W-1:0]    column;
  logic [tbpe_pkg::ROW_W-1:0]    row_number;
  tbpe_pkg::word_t               acc;
  tbpe_pkg::word_t               acc_next;
  logic                          overflow;
  logic                          overflow_next;

  // output register
  logic                          out_valid;
  tbpe_pkg::word_t               out_word;
  logic [tbpe_pkg::ROW_W-1:0]    out_row;
  logic                          out_last;
  logic [tbpe_pkg::COUNT_W-1:0]  out_used;
  logic                          out_overflow;

  logic                          pix_accept;
  logic                          cfg_accept;
  logic                          is_pixel;
  logic                          emit;
  tbpe_pkg::colour_t             colour;
  tbpe_pkg::index_t              idx;
  tbpe_pkg::index_t              add_idx;
  logic                          hit;
  logic [tbpe_pkg::ROW_PIXELS-1:0] column_bit;

  // only a transaction at the last column waits on the output register
  assign pix.ready  = !out_valid || row.ready || (column != tbpe_pkg::LAST_COLUMN);
  assign cfg.ready  = 1'b1;
  assign pix_accept = pix.valid && pix.ready;
  assign cfg_accept = cfg.valid && cfg.ready;
  assign is_pixel   = (pix.kind == tbpe_pkg::KIND_PIXEL);
  assign emit       = is_pixel && (column == tbpe_pkg::LAST_COLUMN);

  // reduced colour, red in the low bits
  assign colour = {pix.blue[7:6], pix.green[7:6], pix.red[7:6]};

  // index given to an appended colour
  assign add_idx = tbpe_pkg::INDEX_W'(fill);

  // preset unpacking and count saturation
  always_comb begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (i < tbpe_pkg::PRESET_PER) begin
        preset_colours[i] = preset_low[(i % tbpe_pkg::PRESET_PER) * tbpe_pkg::COLOUR_W
                                       +: tbpe_pkg::COLOUR_W];
      end else begin
        preset_colours[i] = preset_high[(i % tbpe_pkg::PRESET_PER) * tbpe_pkg::COLOUR_W
                                        +: tbpe_pkg::COLOUR_W];
      end
    end
    if (preset_count > COUNT_MAX) begin
      preset_fill = FILL_FULL;
    end else begin
      preset_fill = preset_count[FW-1:0];
    end
  end

  // palette match: lowest matching entry in use wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = PALETTE_ENTRIES - 1; i >= 0; i--) begin
      if ((i < int'(fill)) && (palette[i] == colour)) begin
        hit = 1'b1;
        idx = tbpe_pkg::INDEX_W'(i);
      end
    end
  end

  // pixel update: index choice, append, plane bits
  always_comb begin
    palette_next  = palette;
    fill_next     = fill;
    overflow_next = overflow;
    column_bit    = tbpe_pkg::ROW_PIXELS'(8'h80 >> column);
    acc_next      = acc;
    if (pix.alpha != '0 && !hit) begin
      if (fill == FILL_FULL) begin
        overflow_next = 1'b1;
      end else begin
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
          if (i == int'(fill)) begin
            palette_next[i] = colour;
          end
        end
        fill_next = fill + 1'b1;
      end
    end
    for (int p = 0; p < tbpe_pkg::PLANES; p++) begin
      if (pix.alpha != '0 && (hit ? idx[p] : (fill != FILL_FULL && add_idx[p]))) begin
        acc_next[p * tbpe_pkg::ROW_PIXELS +: tbpe_pkg::ROW_PIXELS] =
          acc[p * tbpe_pkg::ROW_PIXELS +: tbpe_pkg::ROW_PIXELS] | column_bit;
      end
    end
  end

  // state and register updates
  always_ff @(posedge clk) begin
    if (rst) begin
      preset_low   <= '0;
      preset_high  <= '0;
      preset_count <= '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette[i] <= '0;
      end
      fill       <= '0;
      column     <= '0;
      row_number <= '0;
      acc        <= '0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_accept) begin
        case (cfg.index)
          tbpe_pkg::REG_PRESET_LOW:   preset_low   <= cfg.data;
          tbpe_pkg::REG_PRESET_HIGH:  preset_high  <= cfg.data;
          tbpe_pkg::REG_PRESET_COUNT: preset_count <= cfg.data[tbpe_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (pix_accept && !is_pixel) begin
        palette    <= preset_colours;
        fill       <= preset_fill;
        column     <= '0;
        row_number <= '0;
        acc        <= '0;
        overflow   <= 1'b0;
      end else if (pix_accept) begin
        palette  <= palette_next;
        fill     <= fill_next;
        overflow <= overflow_next;
        column   <= column + 1'b1;
        if (emit) begin
          acc        <= '0;
          row_number <= row_number + 1'b1;
        end else begin
          acc <= acc_next;
        end
      end
      if (pix_accept && emit) begin
        out_valid <= 1'b1;
      end else if (row.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded when a row completes
  always_ff @(posedge clk) begin
    if (pix_accept && emit) begin
      out_word     <= acc_next;
      out_row      <= row_number;
      out_last     <= (row_number == tbpe_pkg::LAST_ROW);
      out_used     <= tbpe_pkg::COUNT_W'(fill_next);
      out_overflow <= overflow_next;
    end
  end

  assign row.valid            = out_valid;
  assign row.row_word         = out_word;
  assign row.tile_row         = out_row;
  assign row.last_row         = out_last;
  assign row.palette_used     = out_used;
  assign row.palette_overflow = out_overflow;

  // checks on fill, overflow, restart and the output register
  `TBPE_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FILL_FULL)
  `TBPE_ASSERT_NOW(a_overflow_full, clk, rst, overflow, fill == FILL_FULL)
  `TBPE_ASSERT_NEXT(a_restart_clears, clk, rst, pix_accept && !is_pixel,
    column == '0 && acc == '0 && !overflow)
  `TBPE_ASSERT_NEXT(a_row_emits, clk, rst, pix_accept && emit, out_valid)
  `TBPE_ASSERT_NOW(a_stall_cause, clk, rst, !pix.ready, out_valid && !row.ready)

endmodule
